### rtl/core/psm_pkg.sv
// Shared types, opcodes and constants of the stack machine step block.
// No dependencies; the stack RAM, divider and top level in rtl/core import it.
package psm_pkg;

    localparam int STACK_DEPTH_DEF = 1024;
    localparam int CODE_DEPTH_DEF  = 1024;
    localparam int MAX_LEVEL_DEF   = 15;

    localparam int WORD_W   = 32;
    localparam int LEVEL_W  = 4;
    localparam int OP_W     = 5;
    localparam int PC_OUT_W = 10;
    localparam int IDX_W    = 34;
    localparam int MAX_WR   = 3;

    // call frame layout relative to the frame base
    localparam int DYN_LINK_OFS = 1;
    localparam int RET_PC_OFS   = 2;
    localparam int STAT_LINK_OFS = 3;
    localparam int FRAME_LAST_OFS = 4;

    typedef enum logic [OP_W-1:0] {
        OP_LA, OP_LV, OP_LC, OP_LI, OP_INT, OP_DCT, OP_J, OP_FJ,
        OP_HL, OP_ST, OP_CALL, OP_EP, OP_EF, OP_RC, OP_RI, OP_WRC,
        OP_WRI, OP_WLN, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NEG,
        OP_CV, OP_EQ, OP_NE, OP_GT, OP_LT, OP_GE, OP_LE, OP_BP
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE, KIND_CHAR, KIND_INT, KIND_NEWLINE
    } kind_t;

    typedef enum logic [1:0] {
        FLT_NONE, FLT_ZERO_DIV, FLT_INDEX
    } fault_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RD1, S_RD2, S_WALK, S_WALK_WAIT,
        S_EXEC, S_DIV, S_WR, S_DONE
    } state_t;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [LEVEL_W-1:0]       level;
        logic signed [WORD_W-1:0] operand;
        logic signed [WORD_W-1:0] read_value;
    } instr_t;

    typedef struct packed {
        logic [PC_OUT_W-1:0]      next_pc;
        logic [1:0]               out_kind;
        logic signed [WORD_W-1:0] out_value;
        logic                     halted;
        logic [1:0]               fault;
    } result_t;

    typedef struct packed {
        logic              start;
        logic              signed_op;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } div_rsp_t;

    function automatic logic [WORD_W-1:0] magnitude(input logic [WORD_W-1:0] v,
                                                    input logic is_signed);
        return (is_signed && v[WORD_W-1]) ? WORD_W'(0) - v : v;
    endfunction

endpackage

### rtl/core/psm_stream_if.sv
// Valid/ready stream channel carrying one payload beat of type T.
// No dependencies; payload types come from psm_pkg at the instance.
interface psm_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/psm_stack_ram.sv
// Data stack memory: one write port, one read port, registered read data.
// Depends on psm_pkg for the word width.
module psm_stack_ram #(
    parameter int DEPTH = psm_pkg::STACK_DEPTH_DEF,
    parameter int AW    = $clog2(psm_pkg::STACK_DEPTH_DEF)
) (
    input  logic                      clk,
    input  logic                      we,
    input  logic [AW-1:0]             waddr,
    input  logic [psm_pkg::WORD_W-1:0] wdata,
    input  logic                      re,
    input  logic [AW-1:0]             raddr,
    output logic [psm_pkg::WORD_W-1:0] rdata
);
    import psm_pkg::*;

    logic [WORD_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/core/psm_divider.sv
// Radix-2 restoring divider, signed or unsigned, one quotient bit per cycle.
// Depends on psm_pkg for the request and response structs.
module psm_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  psm_pkg::div_req_t req,
    output psm_pkg::div_rsp_t rsp
);
    import psm_pkg::*;

    localparam int CNT_W = $clog2(WORD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(WORD_W - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [WORD_W-1:0] quo_reg, quo_next;
    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic              neg_q_reg, neg_q_next;
    logic              neg_r_reg, neg_r_next;
    logic [WORD_W:0]   rem_shift;
    logic [WORD_W+1:0] rem_diff;

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        quo_next   = quo_reg;
        rem_next   = rem_reg;
        dvs_next   = dvs_reg;
        neg_q_next = neg_q_reg;
        neg_r_next = neg_r_reg;
        rem_shift  = {rem_reg, quo_reg[WORD_W-1]};
        rem_diff   = {1'b0, rem_shift} - {2'b00, dvs_reg};
        if (req.start)
        begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            quo_next   = magnitude(req.dividend, req.signed_op);
            rem_next   = '0;
            dvs_next   = magnitude(req.divisor, req.signed_op);
            neg_q_next = req.signed_op & (req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1]);
            neg_r_next = req.signed_op & req.dividend[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!rem_diff[WORD_W+1])
            begin
                rem_next = rem_diff[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[WORD_W-1:0];
                quo_next = {quo_reg[WORD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg   <= quo_next;
        rem_reg   <= rem_next;
        dvs_reg   <= dvs_next;
        neg_q_reg <= neg_q_next;
        neg_r_reg <= neg_r_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = neg_q_reg ? WORD_W'(0) - quo_reg : quo_reg;
    assign rsp.remainder = neg_r_reg ? WORD_W'(0) - rem_reg : rem_reg;

endmodule

### rtl/core/pcode_stack_machine_step.sv
// Top level of the stack machine step block: sequencer, machine registers,
// stack memory and divider. Depends on psm_pkg, psm_stream_if, psm_stack_ram
// and psm_divider.
//
// Usage: each beat on instr carries one instruction (operation, level,
// operand) plus the console value for RC/RI. Each accepted beat yields exactly
// one beat on result: next pc, console output kind and value, halt flag and
// fault code. One instruction is in flight at a time.
// Path from accept to result valid: register-only instructions skip the stack;
// some read the stack twice and write it, CALL makes its three writes, each
// static link followed adds a stack read, and the divider runs for DIV, MOD,
// and jumps when CODE_DEPTH is not a power of two. The stack memory, with one
// port per direction and one access per cycle, and the bit-serial divider set
// the length of each path.
// The result sits in an output register; the next instruction is accepted
// while it waits, and that instruction stalls in its final cycle until the
// receiver takes the earlier result.
// Reset: top index -1, frame base 0, pc 0, not halted. The stack memory is
// not cleared. A faulting instruction changes no machine state.
module pcode_stack_machine_step #(
    parameter int STACK_DEPTH = psm_pkg::STACK_DEPTH_DEF,
    parameter int CODE_DEPTH  = psm_pkg::CODE_DEPTH_DEF,
    parameter int MAX_LEVEL   = psm_pkg::MAX_LEVEL_DEF
) (
    input logic          clk,
    input logic          rst_n,
    psm_stream_if.sink   instr,
    psm_stream_if.source result
);
    import psm_pkg::*;

    localparam int AW  = $clog2(STACK_DEPTH);
    localparam int TW  = AW + 1;
    localparam int PCW = $clog2(CODE_DEPTH);
    localparam bit CODE_POW2 = (CODE_DEPTH & (CODE_DEPTH - 1)) == 0;
    localparam logic signed [IDX_W-1:0] SD_I = IDX_W'(STACK_DEPTH);

    function automatic logic in_stack(input logic signed [IDX_W-1:0] v);
        return (v >= 0) && (v < SD_I);
    endfunction

    state_t state_reg, state_next;

    logic [OP_W-1:0]          op_raw_reg, op_raw_next;
    op_t                      op;
    logic [LEVEL_W-1:0]       lvl_reg, lvl_next;
    logic [LEVEL_W-1:0]       lvl_eff;
    logic signed [WORD_W-1:0] q_reg, q_next;
    logic signed [WORD_W-1:0] rv_reg, rv_next;
    logic signed [WORD_W-1:0] x_reg, x_next;
    logic signed [WORD_W-1:0] y_reg, y_next;
    logic signed [WORD_W-1:0] c_reg, c_next;

    logic signed [TW-1:0] top_reg, top_next;
    logic [AW-1:0]        base_reg, base_next;
    logic [PCW-1:0]       pc_reg, pc_next;
    logic                 halt_reg, halt_next;

    logic signed [TW-1:0] nt_reg, nt_next;
    logic [AW-1:0]        nb_reg, nb_next;
    logic [PCW-1:0]       npc_reg, npc_next;
    logic                 nh_reg, nh_next;
    kind_t                kind_reg, kind_next;
    logic [WORD_W-1:0]    oval_reg, oval_next;
    fault_t               fault_reg, fault_next;
    logic                 ign_reg, ign_next;

    logic [AW-1:0]     wa_reg [MAX_WR];
    logic [AW-1:0]     wa_next [MAX_WR];
    logic [WORD_W-1:0] wv_reg [MAX_WR];
    logic [WORD_W-1:0] wv_next [MAX_WR];
    logic [1:0]        nw_reg, nw_next;
    logic [1:0]        wi_reg, wi_next;

    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;

    logic                    ram_we, ram_re;
    logic [AW-1:0]           ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;
    logic signed [IDX_W-1:0] rd_idx;
    logic [WORD_W-1:0]       ram_q;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic signed [IDX_W-1:0] t_i, b_i, q_i, c_i, x_i, y_i;
    logic [PCW-1:0]          pc_inc;
    logic                    accept, out_load;
    logic                    dec_ok, rd1_more, walk_op;

    logic signed [IDX_W-1:0] ex_nt, ex_nb;
    logic signed [IDX_W-1:0] ex_wa [MAX_WR];
    logic [WORD_W-1:0]       ex_wv [MAX_WR];
    logic [1:0]              ex_nw;
    logic                    ex_nh, ex_idx_ok, ex_zdiv, ex_jump, ex_arith_div, ex_div_go;
    kind_t                   ex_kind;
    logic [WORD_W-1:0]       ex_oval, ex_tgt, ex_alu;
    fault_t                  ex_fault;

    psm_stack_ram #(.DEPTH(STACK_DEPTH), .AW(AW)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_q)
    );

    psm_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign op     = op_t'(op_raw_reg);
    assign t_i    = IDX_W'(top_reg);
    assign b_i    = IDX_W'(base_reg);
    assign q_i    = IDX_W'(q_reg);
    assign c_i    = IDX_W'(c_reg);
    assign x_i    = IDX_W'(x_reg);
    assign y_i    = IDX_W'(y_reg);
    assign pc_inc = (pc_reg == PCW'(CODE_DEPTH - 1)) ? '0 : pc_reg + 1'b1;
    assign lvl_eff = (int'(lvl_reg) > MAX_LEVEL) ? LEVEL_W'(MAX_LEVEL) : lvl_reg;

    assign instr.ready  = (state_reg == S_IDLE);
    assign accept       = instr.valid && instr.ready;
    assign out_load     = (state_reg == S_DONE) && (!out_valid_reg || result.ready);
    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

    // decode-time index checks and routing
    always_comb
    begin
        dec_ok   = 1'b1;
        rd1_more = 1'b0;
        walk_op  = 1'b0;
        unique case (op) inside
            OP_LA, OP_LV:
            begin
                dec_ok  = in_stack(t_i + 1);
                walk_op = 1'b1;
            end
            OP_LC:
                dec_ok = in_stack(t_i + 1);
            OP_LI:
            begin
                dec_ok   = in_stack(t_i);
                rd1_more = 1'b1;
            end
            OP_RC, OP_RI, OP_WRC, OP_WRI, OP_NEG, OP_FJ:
                dec_ok = in_stack(t_i);
            OP_CV:
                dec_ok = in_stack(t_i) && in_stack(t_i + 1);
            OP_ST, [OP_ADD:OP_MOD], [OP_EQ:OP_LE]:
            begin
                dec_ok   = in_stack(t_i - 1) && in_stack(t_i);
                rd1_more = 1'b1;
            end
            OP_EP, OP_EF:
            begin
                dec_ok   = in_stack(b_i + DYN_LINK_OFS) && in_stack(b_i + RET_PC_OFS);
                rd1_more = 1'b1;
            end
            OP_CALL:
            begin
                dec_ok  = in_stack(t_i + RET_PC_OFS) && in_stack(t_i + FRAME_LAST_OFS);
                walk_op = 1'b1;
            end
            OP_INT, OP_DCT, OP_J, OP_HL, OP_WLN, OP_BP:
                dec_ok = 1'b1;
        endcase
    end

    // execute: results, writes and final checks
    always_comb
    begin
        ex_nt        = t_i;
        ex_nb        = b_i;
        ex_nh        = 1'b0;
        ex_kind      = KIND_NONE;
        ex_oval      = '0;
        ex_nw        = '0;
        ex_idx_ok    = 1'b1;
        ex_zdiv      = 1'b0;
        ex_jump      = 1'b0;
        ex_tgt       = q_reg;
        ex_arith_div = 1'b0;
        ex_alu       = '0;
        for (int i = 0; i < MAX_WR; i++)
        begin
            ex_wa[i] = t_i;
            ex_wv[i] = '0;
        end
        unique case (op) inside
            [OP_ADD:OP_MOD], [OP_EQ:OP_LE]:
            begin
                unique case (op) inside
                    OP_ADD: ex_alu = x_reg + y_reg;
                    OP_SUB: ex_alu = x_reg - y_reg;
                    OP_MUL: ex_alu = x_reg * y_reg;
                    OP_EQ:  ex_alu = WORD_W'(x_reg == y_reg);
                    OP_NE:  ex_alu = WORD_W'(x_reg != y_reg);
                    OP_GT:  ex_alu = WORD_W'(x_reg > y_reg);
                    OP_LT:  ex_alu = WORD_W'(x_reg < y_reg);
                    OP_GE:  ex_alu = WORD_W'(x_reg >= y_reg);
                    OP_LE:  ex_alu = WORD_W'(x_reg <= y_reg);
                    default: ex_alu = '0;
                endcase
                ex_arith_div = (op == OP_DIV) || (op == OP_MOD);
                ex_zdiv  = ex_arith_div && (y_reg == 0);
                ex_nt    = t_i - 1;
                ex_nw    = 2'd1;
                ex_wa[0] = t_i - 1;
                ex_wv[0] = ex_alu;
            end
            OP_LA:
            begin
                ex_nt    = t_i + 1;
                ex_nw    = 2'd1;
                ex_wa[0] = t_i + 1;
                ex_wv[0] = WORD_W'(c_i + q_i);
            end
            OP_LV:
            begin
                ex_nt    = t_i + 1;
                ex_nw    = 2'd1;
                ex_wa[0] = t_i + 1;
                ex_wv[0] = y_reg;
            end
            OP_LC:
            begin
                ex_nt    = t_i + 1;
                ex_nw    = 2'd1;
                ex_wa[0] = t_i + 1;
                ex_wv[0] = q_reg;
            end
            OP_LI:
            begin
                ex_idx_ok = in_stack(x_i);
                ex_nw     = 2'd1;
                ex_wv[0]  = y_reg;
            end
            OP_INT: ex_nt = t_i + q_i;
            OP_DCT: ex_nt = t_i - q_i;
            OP_J:   ex_jump = 1'b1;
            OP_FJ:
            begin
                ex_nt   = t_i - 1;
                ex_jump = (x_reg == 0);
            end
            OP_HL: ex_nh = 1'b1;
            OP_ST:
            begin
                ex_idx_ok = in_stack(x_i);
                ex_nt     = t_i - 2;
                ex_nw     = 2'd1;
                ex_wa[0]  = x_i;
                ex_wv[0]  = y_reg;
            end
            OP_CALL:
            begin
                ex_nb    = t_i + 1;
                ex_jump  = 1'b1;
                ex_nw    = 2'd3;
                ex_wa[0] = t_i + RET_PC_OFS;
                ex_wv[0] = WORD_W'(base_reg);
                ex_wa[1] = t_i + STAT_LINK_OFS;
                ex_wv[1] = WORD_W'(pc_reg);
                ex_wa[2] = t_i + FRAME_LAST_OFS;
                ex_wv[2] = c_reg;
            end
            OP_EP, OP_EF:
            begin
                ex_nt   = (op == OP_EP) ? b_i - 1 : b_i;
                ex_nb   = x_i;
                ex_jump = 1'b1;
                ex_tgt  = y_reg + 1'b1;
            end
            OP_RC, OP_RI:
            begin
                ex_idx_ok = in_stack(x_i);
                ex_nt     = t_i - 1;
                ex_nw     = 2'd1;
                ex_wa[0]  = x_i;
                ex_wv[0]  = rv_reg;
            end
            OP_WRC:
            begin
                ex_kind = KIND_CHAR;
                ex_oval = {{(WORD_W-8){1'b0}}, x_reg[7:0]};
                ex_nt   = t_i - 1;
            end
            OP_WRI:
            begin
                ex_kind = KIND_INT;
                ex_oval = x_reg;
                ex_nt   = t_i - 1;
            end
            OP_WLN: ex_kind = KIND_NEWLINE;
            OP_NEG:
            begin
                ex_nw    = 2'd1;
                ex_wv[0] = WORD_W'(0) - x_reg;
            end
            OP_CV:
            begin
                ex_nt    = t_i + 1;
                ex_nw    = 2'd1;
                ex_wa[0] = t_i + 1;
                ex_wv[0] = x_reg;
            end
            OP_BP: ex_nw = '0;
        endcase

        if (!ex_idx_ok)
            ex_fault = FLT_INDEX;
        else if (ex_zdiv)
            ex_fault = FLT_ZERO_DIV;
        else if (ex_nt < -1 || ex_nt >= SD_I || !in_stack(ex_nb))
            ex_fault = FLT_INDEX;
        else
            ex_fault = FLT_NONE;

        ex_div_go = ex_arith_div || (ex_jump && !CODE_POW2);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_DECODE;
            S_DECODE:
                if (halt_reg || !dec_ok)
                    state_next = S_DONE;
                else if (walk_op)
                    state_next = S_WALK;
                else if (op == OP_LI || op == OP_RC || op == OP_RI || op == OP_WRC ||
                         op == OP_WRI || op == OP_NEG || op == OP_FJ || op == OP_CV ||
                         rd1_more)
                    state_next = S_RD1;
                else
                    state_next = S_EXEC;
            S_RD1:
                state_next = rd1_more ? S_RD2 : S_EXEC;
            S_RD2:
                state_next = S_EXEC;
            S_WALK:
                if (lvl_reg == '0)
                begin
                    if (op == OP_LV)
                        state_next = in_stack(c_i + q_i) ? S_RD2 : S_DONE;
                    else
                        state_next = S_EXEC;
                end
                else
                    state_next = in_stack(c_i + STAT_LINK_OFS) ? S_WALK_WAIT : S_DONE;
            S_WALK_WAIT:
                state_next = S_WALK;
            S_EXEC:
                if (ex_fault != FLT_NONE)
                    state_next = S_DONE;
                else if (ex_div_go)
                    state_next = S_DIV;
                else if (ex_nw != '0)
                    state_next = S_WR;
                else
                    state_next = S_DONE;
            S_DIV:
                if (div_rsp.done)
                    state_next = (nw_reg != '0) ? S_WR : S_DONE;
            S_WR:
                if (wi_reg == nw_reg - 1'b1)
                    state_next = S_DONE;
            S_DONE:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        op_raw_next    = op_raw_reg;
        lvl_next       = lvl_reg;
        q_next         = q_reg;
        rv_next        = rv_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        c_next         = c_reg;
        top_next       = top_reg;
        base_next      = base_reg;
        pc_next        = pc_reg;
        halt_next      = halt_reg;
        nt_next        = nt_reg;
        nb_next        = nb_reg;
        npc_next       = npc_reg;
        nh_next        = nh_reg;
        kind_next      = kind_reg;
        oval_next      = oval_reg;
        fault_next     = fault_reg;
        ign_next       = ign_reg;
        wa_next        = wa_reg;
        wv_next        = wv_reg;
        nw_next        = nw_reg;
        wi_next        = wi_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        ram_we         = 1'b0;
        ram_waddr      = wa_reg[wi_reg];
        ram_wdata      = wv_reg[wi_reg];
        ram_re         = 1'b0;
        rd_idx         = t_i;
        div_req        = '0;

        unique case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    op_raw_next = instr.data.operation;
                    lvl_next    = instr.data.level;
                    q_next      = instr.data.operand;
                    rv_next     = instr.data.read_value;
                    fault_next  = FLT_NONE;
                    ign_next    = 1'b0;
                    kind_next   = KIND_NONE;
                    oval_next   = '0;
                    nh_next     = 1'b0;
                    nw_next     = '0;
                    wi_next     = '0;
                end
            S_DECODE:
            begin
                npc_next = pc_inc;
                c_next   = WORD_W'(base_reg);
                lvl_next = lvl_eff;
                if (halt_reg)
                    ign_next = 1'b1;
                else if (!dec_ok)
                    fault_next = FLT_INDEX;
                else
                begin
                    ram_re = 1'b1;
                    rd_idx = (rd1_more && op != OP_LI) ?
                             ((op == OP_EP || op == OP_EF) ? b_i + DYN_LINK_OFS : t_i - 1) :
                             t_i;
                end
            end
            S_RD1:
            begin
                x_next = ram_q;
                ram_re = rd1_more;
                unique case (op) inside
                    OP_LI:        rd_idx = IDX_W'($signed(ram_q));
                    OP_EP, OP_EF: rd_idx = b_i + RET_PC_OFS;
                    default:      rd_idx = t_i;
                endcase
            end
            S_RD2:
                y_next = ram_q;
            S_WALK:
                if (lvl_reg == '0)
                begin
                    if (op == OP_LV)
                    begin
                        rd_idx = c_i + q_i;
                        if (in_stack(c_i + q_i))
                            ram_re = 1'b1;
                        else
                            fault_next = FLT_INDEX;
                    end
                end
                else
                begin
                    rd_idx = c_i + STAT_LINK_OFS;
                    if (in_stack(c_i + STAT_LINK_OFS))
                        ram_re = 1'b1;
                    else
                        fault_next = FLT_INDEX;
                end
            S_WALK_WAIT:
            begin
                c_next   = ram_q;
                lvl_next = lvl_reg - 1'b1;
            end
            S_EXEC:
            begin
                fault_next = ex_fault;
                nt_next    = ex_nt[TW-1:0];
                nb_next    = ex_nb[AW-1:0];
                nh_next    = ex_nh;
                kind_next  = ex_kind;
                oval_next  = ex_oval;
                nw_next    = ex_nw;
                wi_next    = '0;
                for (int i = 0; i < MAX_WR; i++)
                begin
                    wa_next[i] = ex_wa[i][AW-1:0];
                    wv_next[i] = ex_wv[i];
                end
                if (ex_jump && CODE_POW2)
                    npc_next = ex_tgt[PCW-1:0];
                if (ex_fault == FLT_NONE && ex_div_go)
                begin
                    div_req.start     = 1'b1;
                    div_req.signed_op = ex_arith_div;
                    div_req.dividend  = ex_arith_div ? x_reg : ex_tgt;
                    div_req.divisor   = ex_arith_div ? y_reg : WORD_W'(CODE_DEPTH);
                end
            end
            S_DIV:
                if (div_rsp.done)
                begin
                    unique case (op) inside
                        OP_DIV:  wv_next[0] = div_rsp.quotient;
                        OP_MOD:  wv_next[0] = div_rsp.remainder;
                        default: npc_next = div_rsp.remainder[PCW-1:0];
                    endcase
                end
            S_WR:
            begin
                ram_we  = 1'b1;
                wi_next = wi_reg + 1'b1;
            end
            S_DONE:
                if (out_load)
                begin
                    out_valid_next     = 1'b1;
                    out_next.next_pc   = PC_OUT_W'(pc_reg);
                    out_next.out_kind  = KIND_NONE;
                    out_next.out_value = '0;
                    out_next.halted    = ign_reg;
                    out_next.fault     = fault_reg;
                    if (!ign_reg && fault_reg == FLT_NONE)
                    begin
                        out_next.next_pc   = PC_OUT_W'(npc_reg);
                        out_next.out_kind  = kind_reg;
                        out_next.out_value = oval_reg;
                        out_next.halted    = nh_reg;
                        top_next  = nt_reg;
                        base_next = nb_reg;
                        pc_next   = npc_reg;
                        halt_next = nh_reg;
                    end
                end
            default:
                out_valid_next = out_valid_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            top_reg       <= '1;
            base_reg      <= '0;
            pc_reg        <= '0;
            halt_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            fault_reg     <= FLT_NONE;
            ign_reg       <= 1'b0;
            nw_reg        <= '0;
            wi_reg        <= '0;
            lvl_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            base_reg      <= base_next;
            pc_reg        <= pc_next;
            halt_reg      <= halt_next;
            out_valid_reg <= out_valid_next;
            fault_reg     <= fault_next;
            ign_reg       <= ign_next;
            nw_reg        <= nw_next;
            wi_reg        <= wi_next;
            lvl_reg       <= lvl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_raw_reg <= op_raw_next;
        q_reg      <= q_next;
        rv_reg     <= rv_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        c_reg      <= c_next;
        nt_reg     <= nt_next;
        nb_reg     <= nb_next;
        npc_reg    <= npc_next;
        nh_reg     <= nh_next;
        kind_reg   <= kind_next;
        oval_reg   <= oval_next;
        wa_reg     <= wa_next;
        wv_reg     <= wv_next;
        out_reg    <= out_next;
    end

    a_fault_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && fault_reg != FLT_NONE) |=> $stable(pc_reg) && $stable(top_reg))
        else $error("faulting instruction changed machine state");

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        halt_reg |=> halt_reg)
        else $error("halt flag cleared without reset");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside its wait state");

    a_write_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WR && $past(state_reg) != S_WR) |->
            ($past(state_reg) == S_EXEC || $past(state_reg) == S_DIV))
        else $error("stack write started without execute");

endmodule

### tb/psm_step_checker.sv
// Checker for the stack machine step block: watches the instr and result
// channels, predicts each result and compares it field by field.
// Depends on psm_pkg and psm_stream_if.
module psm_step_checker
    import psm_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    psm_stream_if  instr_mon,
    psm_stream_if  result_mon,
    output int     failures,
    output int     pending,
    output int     checked,
    output int     fault_count
);

    localparam int DEPTH = 1024;

    logic [31:0] stack_mem [0:DEPTH-1];
    longint      top_idx;
    longint      base_idx;
    logic [9:0]  pc_reg;
    bit          halt_reg;
    result_t     expected_results[$];

    function automatic bit in_range(longint i);
        return i >= 0 && i < DEPTH;
    endfunction

    function automatic longint word_at(longint i);
        return longint'($signed(stack_mem[i]));
    endfunction

    function automatic bit follow_links(int lv, output longint frame);
        longint cur;
        cur = base_idx;
        frame = 0;
        if (lv > MAX_LEVEL_DEF)
            lv = MAX_LEVEL_DEF;
        while (lv > 0)
        begin
            if (!in_range(cur + STAT_LINK_OFS))
                return 0;
            cur = word_at(cur + STAT_LINK_OFS);
            lv--;
        end
        frame = cur;
        return 1;
    endfunction

    function automatic result_t execute_instr(instr_t it);
        op_t         op;
        longint      q, t, b, nt, nb, c, x, y;
        logic [9:0]  npc;
        longint      wa[3];
        logic [31:0] wv[3];
        int          nw;
        kind_t       kind;
        fault_t      flt;
        logic [31:0] oval;
        bit          nh;
        result_t     r;
        op   = op_t'(it.operation);
        q    = longint'(it.operand);
        t    = top_idx;
        b    = base_idx;
        nt   = t;
        nb   = b;
        c    = 0;
        npc  = pc_reg + 10'd1;
        nw   = 0;
        kind = KIND_NONE;
        flt  = FLT_NONE;
        oval = 0;
        nh   = 0;
        r    = '0;
        if (halt_reg)
        begin
            r.next_pc = pc_reg;
            r.halted  = 1'b1;
            return r;
        end
        case (op)
            OP_LA, OP_LV, OP_LC:
            begin
                nt = t + 1;
                if (!in_range(nt))
                    flt = FLT_INDEX;
                else if (op == OP_LC)
                begin
                    wa[0] = nt; wv[0] = 32'(q); nw = 1;
                end
                else if (!follow_links(int'(it.level), c))
                    flt = FLT_INDEX;
                else if (op == OP_LA)
                begin
                    wa[0] = nt; wv[0] = 32'(c + q); nw = 1;
                end
                else if (!in_range(c + q))
                    flt = FLT_INDEX;
                else
                begin
                    wa[0] = nt; wv[0] = stack_mem[c + q]; nw = 1;
                end
            end
            OP_LI:
                if (!in_range(t) || !in_range(word_at(t)))
                    flt = FLT_INDEX;
                else
                begin
                    wa[0] = t; wv[0] = stack_mem[word_at(t)]; nw = 1;
                end
            OP_INT: nt = t + q;
            OP_DCT: nt = t - q;
            OP_J:   npc = it.operand[9:0];
            OP_FJ:
                if (!in_range(t))
                    flt = FLT_INDEX;
                else
                begin
                    if (stack_mem[t] == 0)
                        npc = it.operand[9:0];
                    nt = t - 1;
                end
            OP_HL: nh = 1;
            OP_ST:
                if (!in_range(t - 1) || !in_range(t) || !in_range(word_at(t - 1)))
                    flt = FLT_INDEX;
                else
                begin
                    wa[0] = word_at(t - 1); wv[0] = stack_mem[t]; nw = 1;
                    nt = t - 2;
                end
            OP_CALL:
                if (!in_range(t + 2) || !in_range(t + 4) ||
                    !follow_links(int'(it.level), c))
                    flt = FLT_INDEX;
                else
                begin
                    wa[0] = t + 2; wv[0] = 32'(b);
                    wa[1] = t + 3; wv[1] = {22'd0, pc_reg};
                    wa[2] = t + 4; wv[2] = 32'(c);
                    nw  = 3;
                    nb  = t + 1;
                    npc = it.operand[9:0];
                end
            OP_EP, OP_EF:
                if (!in_range(b + DYN_LINK_OFS) || !in_range(b + RET_PC_OFS) ||
                    !in_range(word_at(b + DYN_LINK_OFS)))
                    flt = FLT_INDEX;
                else
                begin
                    nt  = (op == OP_EP) ? b - 1 : b;
                    npc = 10'(stack_mem[b + RET_PC_OFS] + 32'd1);
                    nb  = word_at(b + DYN_LINK_OFS);
                end
            OP_RC, OP_RI:
                if (!in_range(t) || !in_range(word_at(t)))
                    flt = FLT_INDEX;
                else
                begin
                    wa[0] = word_at(t); wv[0] = it.read_value; nw = 1;
                    nt = t - 1;
                end
            OP_WRC, OP_WRI:
                if (!in_range(t))
                    flt = FLT_INDEX;
                else
                begin
                    kind = (op == OP_WRC) ? KIND_CHAR : KIND_INT;
                    oval = (op == OP_WRC) ? {24'd0, stack_mem[t][7:0]} : stack_mem[t];
                    nt   = t - 1;
                end
            OP_WLN: kind = KIND_NEWLINE;
            OP_NEG:
                if (!in_range(t))
                    flt = FLT_INDEX;
                else
                begin
                    wa[0] = t; wv[0] = 32'd0 - stack_mem[t]; nw = 1;
                end
            OP_CV:
                if (!in_range(t) || !in_range(t + 1))
                    flt = FLT_INDEX;
                else
                begin
                    wa[0] = t + 1; wv[0] = stack_mem[t]; nw = 1;
                    nt = t + 1;
                end
            OP_BP: ;
            default:
                if (!in_range(t - 1) || !in_range(t))
                    flt = FLT_INDEX;
                else
                begin
                    x  = word_at(t - 1);
                    y  = word_at(t);
                    nt = t - 1;
                    case (op)
                        OP_ADD: x = x + y;
                        OP_SUB: x = x - y;
                        OP_MUL: x = x * y;
                        OP_DIV: if (y == 0) flt = FLT_ZERO_DIV; else x = x / y;
                        OP_MOD: if (y == 0) flt = FLT_ZERO_DIV; else x = x % y;
                        OP_EQ:  x = (x == y);
                        OP_NE:  x = (x != y);
                        OP_GT:  x = (x > y);
                        OP_LT:  x = (x < y);
                        OP_GE:  x = (x >= y);
                        default: x = (x <= y);
                    endcase
                    wa[0] = t - 1; wv[0] = 32'(x); nw = 1;
                end
        endcase
        if (flt == FLT_NONE && (nt < -1 || nt >= DEPTH || !in_range(nb)))
            flt = FLT_INDEX;
        if (flt != FLT_NONE)
        begin
            r.next_pc = pc_reg;
            r.fault   = flt;
            return r;
        end
        for (int i = 0; i < nw; i++)
            stack_mem[wa[i]] = wv[i];
        top_idx   = nt;
        base_idx  = nb;
        pc_reg    = npc;
        halt_reg  = nh;
        r.next_pc   = npc;
        r.out_kind  = kind;
        r.out_value = oval;
        r.halted    = nh;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        result_t got_r;
        if (!rst_n)
        begin
            top_idx     = -1;
            base_idx    = 0;
            pc_reg      = '0;
            halt_reg    = 0;
            failures    = 0;
            checked     = 0;
            fault_count = 0;
            expected_results.delete();
            pending     = 0;
        end
        else
        begin
            if (result_mon.valid && result_mon.ready)
            begin
                got_r = result_mon.data;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with no expectation waiting");
                    failures++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    checked++;
                    if (got_r.fault != 0)
                        fault_count++;
                    if (got_r.next_pc !== exp_r.next_pc)
                    begin
                        $error("next_pc: expected %0d, got %0d", exp_r.next_pc, got_r.next_pc);
                        failures++;
                    end
                    if (got_r.out_kind !== exp_r.out_kind)
                    begin
                        $error("out_kind: expected %0d, got %0d", exp_r.out_kind, got_r.out_kind);
                        failures++;
                    end
                    if (got_r.out_value !== exp_r.out_value)
                    begin
                        $error("out_value: expected %0d, got %0d",
                               exp_r.out_value, got_r.out_value);
                        failures++;
                    end
                    if (got_r.halted !== exp_r.halted)
                    begin
                        $error("halted: expected %0d, got %0d", exp_r.halted, got_r.halted);
                        failures++;
                    end
                    if (got_r.fault !== exp_r.fault)
                    begin
                        $error("fault: expected %0d, got %0d", exp_r.fault, got_r.fault);
                        failures++;
                    end
                end
            end
            if (instr_mon.valid && instr_mon.ready)
                expected_results.push_back(execute_instr(instr_mon.data));
            pending = expected_results.size();
        end
    end

endmodule

### tb/pcode_stack_machine_step_tb.sv
// Top of the stack machine step testbench: clock, reset, instruction
// stimulus, result back-pressure and verdict. Depends on psm_pkg,
// psm_stream_if, psm_step_checker and the block itself.
module pcode_stack_machine_step_tb;
    import psm_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int RANDOM_ITEMS = 400;

    logic clk;
    logic rst_n;
    int   cycles = 0;
    int   sent;
    int   failures;
    int   pending;
    int   checked;
    int   fault_count;
    int   hold_cycles = 0;
    bit   choke_done = 0;
    bit   quiet_mode;

    psm_stream_if #(.T(instr_t))  instr_ch ();
    psm_stream_if #(.T(result_t)) result_ch ();

    pcode_stack_machine_step dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .instr  (instr_ch.sink),
        .result (result_ch.source)
    );

    psm_step_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .instr_mon   (instr_ch),
        .result_mon  (result_ch),
        .failures    (failures),
        .pending     (pending),
        .checked     (checked),
        .fault_count (fault_count)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            result_ch.ready <= 1'b0;
            hold_cycles     <= hold_cycles - 1;
        end
        else if (!choke_done && sent > 1300)
        begin
            result_ch.ready <= 1'b0;
            hold_cycles     <= 400;
            choke_done      <= 1;
        end
        else if (!quiet_mode && $urandom_range(0, 149) == 0)
        begin
            result_ch.ready <= 1'b0;
            hold_cycles     <= $urandom_range(15, 60);
        end
        else
            result_ch.ready <= quiet_mode || ($urandom_range(0, 9) < 7);
    end

    task automatic send_instr(op_t op, int lv, int q, int rv);
        int gap;
        instr_ch.valid <= 1'b1;
        instr_ch.data  <= '{operation: op, level: 4'(lv), operand: q, read_value: rv};
        @(posedge clk);
        while (!instr_ch.ready)
            @(posedge clk);
        sent++;
        if (quiet_mode || $urandom_range(0, 9) < 6)
            gap = 0;
        else if ($urandom_range(0, 9) < 9)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            instr_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_instr();
        op_t op;
        int  pick;
        int  q;
        int  lv;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            op = op_t'($urandom_range(OP_LA, OP_LC));
        else
        begin
            op = op_t'($urandom_range(0, 31));
            while (op == OP_HL)
                op = op_t'($urandom_range(0, 31));
        end
        pick = $urandom_range(0, 9);
        if (op == OP_INT || op == OP_DCT)
            q = (pick < 8) ? $urandom_range(0, 3) : $urandom;
        else if (pick < 5)
            q = $urandom_range(0, 40);
        else if (pick < 7)
            q = $urandom_range(0, 10) - 5;
        else if (pick < 9)
            q = $urandom;
        else
            case ($urandom_range(0, 3))
                0: q = 32'h8000_0000;
                1: q = 32'h7fff_ffff;
                2: q = 0;
                default: q = -1;
            endcase
        lv = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, 15);
        send_instr(op, lv, q, $urandom);
    endtask

    initial
    begin
        rst_n           <= 1'b0;
        instr_ch.valid  <= 1'b0;
        instr_ch.data   <= '0;
        quiet_mode      = 0;
        sent            = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // fill the whole stack so no later read hits an unwritten word
        quiet_mode = 1;
        for (int i = 0; i < 1024; i++)
            send_instr(OP_LC, 0, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 40), 0);
        send_instr(OP_DCT, 0, 1024, 0);
        quiet_mode = 0;

        send_instr(OP_LC, 0, 32'h7fff_ffff, 0);
        send_instr(OP_LC, 0, 32'h8000_0000, 0);
        send_instr(OP_ADD, 0, 0, 0);
        send_instr(OP_LC, 0, -1, 0);
        send_instr(OP_MUL, 0, 0, 0);
        send_instr(OP_WRI, 0, 0, 0);
        send_instr(OP_LC, 0, 32'h1234_5641, 0);
        send_instr(OP_WRC, 0, 0, 0);
        send_instr(OP_WLN, 0, 0, 0);
        send_instr(OP_LC, 0, 32'h8000_0000, 0);
        send_instr(OP_LC, 0, -1, 0);
        send_instr(OP_DIV, 0, 0, 0);
        send_instr(OP_LC, 0, 0, 0);
        send_instr(OP_MOD, 0, 0, 0);
        send_instr(OP_DCT, 0, 5, 0);
        send_instr(OP_INT, 0, 2000, 0);
        send_instr(OP_LA, 15, 3, 0);
        send_instr(OP_CALL, 1, 700, 0);
        send_instr(OP_LV, 1, 2, 0);
        send_instr(OP_RI, 0, 0, 32'h8000_0000);
        send_instr(OP_EF, 0, 0, 0);
        send_instr(OP_CALL, 0, 32'hffff_ffff, 0);
        send_instr(OP_EP, 0, 0, 0);
        send_instr(OP_J, 0, 32'h7fff_ffff, 0);
        send_instr(OP_BP, 0, 0, 0);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % 100 == 50)
                quiet_mode = ~quiet_mode;
            send_random_instr();
        end
        quiet_mode = 0;

        send_instr(OP_HL, 0, 0, 0);
        send_instr(OP_LC, 0, 9, 0);
        send_instr(OP_WLN, 0, 0, 0);
        instr_ch.valid <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        $display("Ran %0d instructions (stack fill, directed, random, halt), %0d results checked",
                 sent, checked);
        $display("Results carrying a fault: %0d", fault_count);
        if (failures == 0 && pending == 0 && checked == sent)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
rtl/core/psm_pkg.sv
rtl/core/psm_stream_if.sv
rtl/core/psm_stack_ram.sv
rtl/core/psm_divider.sv
rtl/core/pcode_stack_machine_step.sv
tb/psm_step_checker.sv
tb/pcode_stack_machine_step_tb.sv
